[sv/gdbm_pkg.sv]
// Shared types, constants and codes for the gated descriptor best-match block.
package gdbm_pkg;

   // Default sizes of the candidate and descriptor stores.
   localparam int MAX_CANDIDATES_DEF = 256;
   localparam int MAX_DESC_LEN_DEF   = 128;
   localparam int ELEM_BITS_DEF      = 8;

   // Configuration port shape and register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 34;

   localparam logic [CSR_INDEX_W-1:0] CSR_DESC_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_SQ   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_LIMIT = 2'd2;

   // Register reset values.
   localparam logic [7:0]  DESC_LENGTH_RST = 8'd64;
   localparam logic [33:0] RADIUS_SQ_RST   = 34'd1048576;
   localparam logic [15:0] SCORE_LIMIT_RST = 16'hFFFF;

   // Input beat command codes.
   typedef enum logic [1:0] {
      CMD_LOAD_POS   = 2'd0,
      CMD_LOAD_ELEM  = 2'd1,
      CMD_LOAD_QUERY = 2'd2,
      CMD_SEARCH     = 2'd3
   } cmd_code_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_POS_RD,
      ST_POS_DIFF,
      ST_POS_SQ,
      ST_POS_GATE,
      ST_ELEM,
      ST_DRAIN,
      ST_SCORE,
      ST_NEXT,
      ST_DONE
   } state_type;

   // Input beat payload.
   typedef struct packed {
      cmd_code_type       command;
      logic [7:0]         cand_index;
      logic [6:0]         elem_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         elem_value;
      logic [7:0]         query_value_a;
      logic [7:0]         query_value_b;
      logic [8:0]         cand_count;
   } req_data_type;

   // Result beat payload.
   typedef struct packed {
      logic        found;
      logic [7:0]  best_index;
      logic [15:0] best_score;
   } rsp_data_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_pos;
      logic wr_elem;
      logic wr_query;
      logic search_start;
      logic elem_clear;
      logic elem_issue;
      logic best_update;
      logic cand_inc;
      logic rsp_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cand_done;
      logic gate_pass;
      logic len_zero;
      logic elem_last;
      logic rsp_free;
   } dp_status_type;

endpackage

[sv/gated_descriptor_best_match_top.sv]
// Top level of the radius-gated two-query SAD descriptor search block.
//
// The request channel (req_valid, req_stall, req_data) carries one command per beat:
// load a candidate position, load a candidate descriptor element, load one element of
// both query descriptors, or start a search. While the block is idle the three load
// commands are accepted back to back. A search holds req_stall high while it walks the
// candidates and then delivers one beat on the result channel (rsp_valid, rsp_stall,
// rsp_data). Per candidate the walk reads the position and gates it against the radius;
// a candidate inside the radius is then scored over L elements, where L is desc_length
// capped at MAX_DESC_LEN, with the descriptor store delivering one element per cycle.
// The result sits in an output register; while the receiver stalls it is held there,
// and a following search waits only at its end for that register.
// The csr port writes desc_length, radius_sq and score_limit and must be used only
// while the block is idle; the block itself does not enforce this. Reset is
// synchronous: it returns the controller to idle, drops rsp_valid and restores the
// register defaults; the stores are not cleared and must be loaded before use.
module gated_descriptor_best_match_top
   import gdbm_pkg::*;
#(
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
   parameter int MAX_DESC_LEN   = MAX_DESC_LEN_DEF,
   parameter int ELEM_BITS      = ELEM_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer.
   gdbm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .status      (status),
      .req_stall   (req_stall),
      .cmd         (cmd)
   );

   // Stores and arithmetic.
   gdbm_datapath #(
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .MAX_DESC_LEN   (MAX_DESC_LEN),
      .ELEM_BITS      (ELEM_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   // An accepted search holds off the request channel on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.command == CMD_SEARCH)) |=> req_stall)
      else $error("request channel not held after search start");

   // The result register is loaded only when it is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // A loaded result is offered on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid)
      else $error("loaded result not offered");

   // A miss reports index zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.best_index == 8'd0))
      else $error("nonzero index on a miss");

endmodule

[sv/gdbm_ctrl.sv]
// Controller state machine that sequences loads and the candidate search.
module gdbm_ctrl
   import gdbm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  cmd_code_type  req_command,
   input  dp_status_type status,
   output logic          req_stall,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_command == CMD_SEARCH)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.cand_done ? ST_DONE : ST_POS_RD;
         end
         ST_POS_RD:   state_in = ST_POS_DIFF;
         ST_POS_DIFF: state_in = ST_POS_SQ;
         ST_POS_SQ:   state_in = ST_POS_GATE;
         ST_POS_GATE: begin
            if (!status.gate_pass) begin
               state_in = ST_NEXT;
            end else if (status.len_zero) begin
               state_in = ST_SCORE;
            end else begin
               state_in = ST_ELEM;
            end
         end
         ST_ELEM: begin
            if (status.elem_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SCORE;
         ST_SCORE: state_in = ST_NEXT;
         ST_NEXT:  state_in = ST_CHECK;
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_command)
                  CMD_LOAD_POS:   cmd.wr_pos       = 1'b1;
                  CMD_LOAD_ELEM:  cmd.wr_elem      = 1'b1;
                  CMD_LOAD_QUERY: cmd.wr_query     = 1'b1;
                  CMD_SEARCH:     cmd.search_start = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_POS_GATE: cmd.elem_clear  = 1'b1;
         ST_ELEM:     cmd.elem_issue  = 1'b1;
         ST_SCORE:    cmd.best_update = 1'b1;
         ST_NEXT:     cmd.cand_inc    = 1'b1;
         ST_DONE:     cmd.rsp_load    = status.rsp_free;
         default: ;
      endcase
   end

endmodule

[sv/gdbm_datapath.sv]
// Datapath: stores, configuration registers, distance gate, SAD accumulator, result register.
module gdbm_datapath
   import gdbm_pkg::*;
#(
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
   parameter int MAX_DESC_LEN   = MAX_DESC_LEN_DEF,
   parameter int ELEM_BITS      = ELEM_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  req_data_type           req_data,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data
);

   localparam int IDX_W   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);
   localparam int EIDX_W  = (MAX_DESC_LEN > 1) ? $clog2(MAX_DESC_LEN) : 1;
   localparam int LEN_W   = $clog2(MAX_DESC_LEN + 1);
   localparam int DEPTH   = MAX_CANDIDATES * MAX_DESC_LEN;
   localparam int DADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SCORE_W = $clog2(2 * MAX_DESC_LEN * ((1 << ELEM_BITS) - 1) + 1);
   localparam int CMP_W   = (SCORE_W > 16) ? SCORE_W : 16;

   // Stores.
   logic [15:0]          cand_x_store_ff [MAX_CANDIDATES];
   logic [15:0]          cand_y_store_ff [MAX_CANDIDATES];
   logic [ELEM_BITS-1:0] cand_desc_store_ff [DEPTH];
   logic [ELEM_BITS-1:0] query_a_store_ff [MAX_DESC_LEN];
   logic [ELEM_BITS-1:0] query_b_store_ff [MAX_DESC_LEN];

   // Configuration registers.
   logic [7:0]  desc_length_ff;
   logic [33:0] radius_sq_ff;
   logic [15:0] score_limit_ff;

   // Search state.
   logic [15:0]          qx_ff;
   logic [15:0]          qy_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CNT_W-1:0]     cand_idx_ff;
   logic [DADDR_W-1:0]   row_base_ff;
   logic [EIDX_W-1:0]    elem_idx_ff;
   logic [LEN_W-1:0]     len_eff;
   logic [15:0]          x_rd_ff;
   logic [15:0]          y_rd_ff;
   logic [16:0]          dx_diff;
   logic [16:0]          dy_diff;
   logic [16:0]          dx_abs_ff;
   logic [16:0]          dy_abs_ff;
   logic [16:0]          dx_abs_in;
   logic [16:0]          dy_abs_in;
   logic [33:0]          sq_x_ff;
   logic [33:0]          sq_y_ff;
   logic [34:0]          dist_sq;
   logic [ELEM_BITS-1:0] cand_rd_ff;
   logic [ELEM_BITS-1:0] qa_rd_ff;
   logic [ELEM_BITS-1:0] qb_rd_ff;
   logic                 elem_valid_ff;
   logic [ELEM_BITS-1:0] diff_a;
   logic [ELEM_BITS-1:0] diff_b;
   logic [SCORE_W-1:0]   score_ff;
   logic [15:0]          best_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic                 found_ff;
   logic                 score_better;
   logic                 rsp_valid_ff;
   rsp_data_type         rsp_data_ff;

   // Write decode for the load commands.
   logic                 slot_ok;
   logic                 elem_ok;
   logic [IDX_W-1:0]     wr_slot;
   logic [EIDX_W-1:0]    wr_elem;
   logic [DADDR_W-1:0]   wr_daddr;
   logic [DADDR_W-1:0]   rd_daddr;

   assign slot_ok  = 32'(req_data.cand_index) < 32'(MAX_CANDIDATES);
   assign elem_ok  = 32'(req_data.elem_index) < 32'(MAX_DESC_LEN);
   assign wr_slot  = IDX_W'(req_data.cand_index);
   assign wr_elem  = EIDX_W'(req_data.elem_index);
   assign wr_daddr = DADDR_W'(32'(req_data.cand_index) * MAX_DESC_LEN
                              + 32'(req_data.elem_index));
   assign rd_daddr = row_base_ff + DADDR_W'(elem_idx_ff);

   // Position stores: one write from a load beat, one read at the current candidate.
   always_ff @(posedge clock) begin
      if (cmd.wr_pos && slot_ok) begin
         cand_x_store_ff[wr_slot] <= req_data.pos_x;
         cand_y_store_ff[wr_slot] <= req_data.pos_y;
      end
      x_rd_ff <= cand_x_store_ff[cand_idx_ff[IDX_W-1:0]];
      y_rd_ff <= cand_y_store_ff[cand_idx_ff[IDX_W-1:0]];
   end

   // Candidate descriptor store.
   always_ff @(posedge clock) begin
      if (cmd.wr_elem && slot_ok && elem_ok) begin
         cand_desc_store_ff[wr_daddr] <= ELEM_BITS'(req_data.elem_value);
      end
      cand_rd_ff <= cand_desc_store_ff[rd_daddr];
   end

   // Query descriptor stores.
   always_ff @(posedge clock) begin
      if (cmd.wr_query && elem_ok) begin
         query_a_store_ff[wr_elem] <= ELEM_BITS'(req_data.query_value_a);
         query_b_store_ff[wr_elem] <= ELEM_BITS'(req_data.query_value_b);
      end
      qa_rd_ff <= query_a_store_ff[elem_idx_ff];
      qb_rd_ff <= query_b_store_ff[elem_idx_ff];
   end

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_length_ff <= DESC_LENGTH_RST;
         radius_sq_ff   <= RADIUS_SQ_RST;
         score_limit_ff <= SCORE_LIMIT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DESC_LENGTH: desc_length_ff <= csr_wdata[7:0];
            CSR_RADIUS_SQ:   radius_sq_ff   <= csr_wdata[33:0];
            CSR_SCORE_LIMIT: score_limit_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Saturate the element count and the candidate count to the store sizes.
   always_comb begin
      if (32'(desc_length_ff) > 32'(MAX_DESC_LEN)) begin
         len_eff = LEN_W'(MAX_DESC_LEN);
      end else begin
         len_eff = LEN_W'(desc_length_ff);
      end
      if (32'(req_data.cand_count) > 32'(MAX_CANDIDATES)) begin
         count_in = CNT_W'(MAX_CANDIDATES);
      end else begin
         count_in = CNT_W'(req_data.cand_count);
      end
   end

   // Search setup and candidate walk.
   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         qx_ff       <= req_data.pos_x;
         qy_ff       <= req_data.pos_y;
         count_ff    <= count_in;
         cand_idx_ff <= '0;
         row_base_ff <= '0;
      end else if (cmd.cand_inc) begin
         cand_idx_ff <= cand_idx_ff + CNT_W'(1);
         row_base_ff <= row_base_ff + DADDR_W'(MAX_DESC_LEN);
      end
   end

   // Distance pipeline: difference and magnitude, then squares.
   always_comb begin
      dx_diff   = {x_rd_ff[15], x_rd_ff} - {qx_ff[15], qx_ff};
      dy_diff   = {y_rd_ff[15], y_rd_ff} - {qy_ff[15], qy_ff};
      dx_abs_in = dx_diff[16] ? (~dx_diff + 17'd1) : dx_diff;
      dy_abs_in = dy_diff[16] ? (~dy_diff + 17'd1) : dy_diff;
      dist_sq   = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   end

   always_ff @(posedge clock) begin
      dx_abs_ff <= dx_abs_in;
      dy_abs_ff <= dy_abs_in;
      sq_x_ff   <= 34'(dx_abs_ff) * 34'(dx_abs_ff);
      sq_y_ff   <= 34'(dy_abs_ff) * 34'(dy_abs_ff);
   end

   // Element counter and read-valid flag for the accumulator.
   always_ff @(posedge clock) begin
      if (cmd.elem_clear) begin
         elem_idx_ff <= '0;
      end else if (cmd.elem_issue) begin
         elem_idx_ff <= elem_idx_ff + EIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_valid_ff <= 1'b0;
      end else begin
         elem_valid_ff <= cmd.elem_issue;
      end
   end

   // Absolute differences against both queries, accumulated one element a cycle.
   always_comb begin
      diff_a = (qa_rd_ff > cand_rd_ff) ? (qa_rd_ff - cand_rd_ff) : (cand_rd_ff - qa_rd_ff);
      diff_b = (qb_rd_ff > cand_rd_ff) ? (qb_rd_ff - cand_rd_ff) : (cand_rd_ff - qb_rd_ff);
      score_better = CMP_W'(score_ff) < CMP_W'(best_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.elem_clear) begin
         score_ff <= '0;
      end else if (elem_valid_ff) begin
         score_ff <= score_ff + SCORE_W'(diff_a) + SCORE_W'(diff_b);
      end
   end

   // Running best; the first strictly smaller score wins.
   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         best_ff     <= score_limit_ff;
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.best_update && score_better) begin
         best_ff     <= 16'(score_ff);
         best_idx_ff <= cand_idx_ff[IDX_W-1:0];
         found_ff    <= 1'b1;
      end
   end

   // Result register: holds a beat while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.found      <= found_ff;
         rsp_data_ff.best_index <= 8'(best_idx_ff);
         rsp_data_ff.best_score <= best_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to the controller.
   always_comb begin
      status.cand_done = cand_idx_ff == count_ff;
      status.gate_pass = dist_sq <= {1'b0, radius_sq_ff};
      status.len_zero  = len_eff == '0;
      status.elem_last = (32'(elem_idx_ff) + 32'd1) == 32'(len_eff);
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule

[bench/testbench.sv]
// Self-checking testbench for the gated descriptor best-match block, scoreboard included.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gdbm_pkg::*;

   localparam int NUM_SLOTS = MAX_CANDIDATES_DEF;
   localparam int DESC_SLOTS = MAX_DESC_LEN_DEF;
   // Index 3 has no register behind it; writes there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [33:0] RADIUS_MAX = 34'h3_FFFF_FFFF;
   // Loads are accepted back to back and the result sits in one register, so a short pause
   // after the last result is enough to see the block idle.
   localparam int SETTLE_CYCLES = 16;
   // The limit sits well above the slowest legal run of this stimulus (initial load, the
   // full-list searches, longest stall bursts on every beat).
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_PHASES = 8;
   localparam int BEATS_PER_PHASE = 40;
   // Initial descriptor load: element 0 of every slot, whole rows for the first few
   // slots and short rows for the next ones.
   localparam int FULL_ROWS = 4;
   localparam int SHORT_ROWS = 16;
   localparam int SHORT_ROW_LEN = 16;

   // Keeps a private copy of the stores and registers and works out each search result.
   class match_scoreboard;
      logic signed [15:0] cand_x [NUM_SLOTS];
      logic signed [15:0] cand_y [NUM_SLOTS];
      logic [7:0] cand_desc [NUM_SLOTS][DESC_SLOTS];
      logic [7:0] query_a [DESC_SLOTS];
      logic [7:0] query_b [DESC_SLOTS];
      bit pos_written [NUM_SLOTS];
      bit desc_written [NUM_SLOTS][DESC_SLOTS];
      logic [7:0] desc_length;
      logic [33:0] radius_sq;
      logic [15:0] score_limit;
      rsp_data_type pending_results[$];
      int errors;
      int searches;
      int hits;
      int accepted;

      function new();
         desc_length = DESC_LENGTH_RST;
         radius_sq = RADIUS_SQ_RST;
         score_limit = SCORE_LIMIT_RST;
         errors = 0;
         searches = 0;
         hits = 0;
         accepted = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_DESC_LENGTH: desc_length = value[7:0];
            CSR_RADIUS_SQ: radius_sq = value[33:0];
            CSR_SCORE_LIMIT: score_limit = value[15:0];
            default: ;
         endcase
      endfunction

      // Number of leading slots whose position and first len elements are all loaded.
      function int ready_count(int len);
         int c;
         bit ok;
         c = 0;
         ok = 1'b1;
         while (ok && c < NUM_SLOTS) begin
            ok = pos_written[c];
            for (int k = 0; k < len; k++) if (!desc_written[c][k]) ok = 1'b0;
            if (ok) c++;
         end
         return c;
      endfunction

      // Walk the candidates in order; the first strictly smaller score wins.
      function rsp_data_type best_match(req_data_type req);
         rsp_data_type res;
         int count;
         int len;
         int best;
         int best_slot;
         int score;
         int qa;
         int qb;
         int cv;
         logic found;
         longint dx;
         longint dy;
         longint dist_sq;
         count = (req.cand_count > NUM_SLOTS) ? NUM_SLOTS : int'(req.cand_count);
         len = (desc_length > DESC_SLOTS) ? DESC_SLOTS : int'(desc_length);
         best = int'(score_limit);
         best_slot = 0;
         found = 1'b0;
         for (int i = 0; i < count; i++) begin
            dx = longint'(cand_x[i]) - longint'($signed(req.pos_x));
            dy = longint'(cand_y[i]) - longint'($signed(req.pos_y));
            dist_sq = dx * dx + dy * dy;
            if (dist_sq > longint'(radius_sq)) continue;
            score = 0;
            for (int k = 0; k < len; k++) begin
               qa = int'(query_a[k]);
               qb = int'(query_b[k]);
               cv = int'(cand_desc[i][k]);
               score += (qa > cv) ? qa - cv : cv - qa;
               score += (qb > cv) ? qb - cv : cv - qb;
            end
            if (score < best) begin
               best = score;
               best_slot = i;
               found = 1'b1;
            end
         end
         res.found = found;
         res.best_index = found ? 8'(best_slot) : 8'd0;
         res.best_score = 16'(best);
         return res;
      endfunction

      function void note_request(req_data_type req);
         accepted++;
         case (req.command)
            CMD_LOAD_POS: begin
               cand_x[req.cand_index] = req.pos_x;
               cand_y[req.cand_index] = req.pos_y;
               pos_written[req.cand_index] = 1'b1;
            end
            CMD_LOAD_ELEM: begin
               cand_desc[req.cand_index][req.elem_index] = req.elem_value;
               desc_written[req.cand_index][req.elem_index] = 1'b1;
            end
            CMD_LOAD_QUERY: begin
               query_a[req.elem_index] = req.query_value_a;
               query_b[req.elem_index] = req.query_value_b;
            end
            CMD_SEARCH: begin
               pending_results.push_back(best_match(req));
               searches++;
            end
            default: ;
         endcase
      endfunction

      function void check_response(rsp_data_type got);
         rsp_data_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat found=%0d index=%0d score=%0d",
                     $time, got.found, got.best_index, got.best_score);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (want.found) hits++;
         if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, got.found);
            errors++;
         end
         if (got.best_index !== want.best_index) begin
            $display("%0t: best_index mismatch, expected %0d, actual %0d",
                     $time, want.best_index, got.best_index);
            errors++;
         end
         if (got.best_score !== want.best_score) begin
            $display("%0t: best_score mismatch, expected %0d, actual %0d",
                     $time, want.best_score, got.best_score);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_data_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_data_type rsp_data;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   match_scoreboard sb;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count = 0;
   logic signed [15:0] center_x = '0;
   logic signed [15:0] center_y = '0;

   gated_descriptor_best_match_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, sb.pending_results.size());
         $display("gated_descriptor_best_match_top test failed");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge; a beat moves when valid and not stall.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // Result receiver: random stall bursts at the rate the current phase asks for.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_pct != 0 && $urandom_range(99, 0) < rsp_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(18, 1)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one beat, with an optional idle burst first, and hold it until accepted.
   task automatic send_request(req_data_type item);
      int gap;
      @(negedge clock);
      if (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(18, 1);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.write_register(index, value);
   endtask

   // Drop valid, wait for every outstanding result, then let the block go quiet.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Every field random; the caller then fixes the ones the command uses.
   function automatic req_data_type random_fields(cmd_code_type cmd);
      req_data_type r;
      r.command = cmd;
      r.cand_index = 8'($urandom);
      r.elem_index = 7'($urandom);
      r.pos_x = 16'($urandom);
      r.pos_y = 16'($urandom);
      r.elem_value = 8'($urandom);
      r.query_value_a = 8'($urandom);
      r.query_value_b = 8'($urandom);
      r.cand_count = 9'($urandom);
      return r;
   endfunction

   function automatic logic signed [15:0] near_center(logic signed [15:0] base);
      int step;
      step = int'($urandom_range(12, 0)) - 6;
      return base + 16'(step * 16);
   endfunction

   // Low slots are the ones that small searches actually visit.
   function automatic logic [7:0] pick_slot();
      return ($urandom_range(99, 0) < 60) ? 8'($urandom_range(23, 0)) : 8'($urandom);
   endfunction

   // A few element values repeat often so that equal scores and first-wins ties occur.
   function automatic logic [7:0] pick_element();
      return ($urandom_range(99, 0) < 50) ? 8'(127 * $urandom_range(2, 0)) : 8'($urandom);
   endfunction

   task automatic load_position(logic [7:0] slot, logic signed [15:0] x,
                                logic signed [15:0] y);
      req_data_type r;
      r = random_fields(CMD_LOAD_POS);
      r.cand_index = slot;
      r.pos_x = x;
      r.pos_y = y;
      send_request(r);
   endtask

   task automatic load_element(logic [7:0] slot, logic [6:0] elem, logic [7:0] value);
      req_data_type r;
      r = random_fields(CMD_LOAD_ELEM);
      r.cand_index = slot;
      r.elem_index = elem;
      r.elem_value = value;
      send_request(r);
   endtask

   task automatic load_query(logic [6:0] elem, logic [7:0] a, logic [7:0] b);
      req_data_type r;
      r = random_fields(CMD_LOAD_QUERY);
      r.elem_index = elem;
      r.query_value_a = a;
      r.query_value_b = b;
      send_request(r);
   endtask

   task automatic request_search(logic signed [15:0] x, logic signed [15:0] y,
                                 logic [8:0] count);
      req_data_type r;
      r = random_fields(CMD_SEARCH);
      r.pos_x = x;
      r.pos_y = y;
      r.cand_count = count;
      send_request(r);
   endtask

   // Random beat: loads that keep refreshing the working set, and searches sized so that
   // long descriptors go with short candidate lists. A search never reaches past the
   // slots whose position and compared elements have been loaded.
   function automatic req_data_type random_item(int len_eff);
      req_data_type r;
      int pick;
      int ready;
      int count_eff;
      pick = $urandom_range(99, 0);
      if (pick < 20) begin
         r = random_fields(CMD_SEARCH);
         if ($urandom_range(99, 0) < 85) begin
            r.pos_x = near_center(center_x);
            r.pos_y = near_center(center_y);
         end
         pick = $urandom_range(99, 0);
         if (pick < 3) r.cand_count = 9'd0;
         else if (pick < 6 && len_eff <= 16) r.cand_count = 9'($urandom_range(511, 256));
         else if (len_eff > 32) r.cand_count = 9'($urandom_range(8, 1));
         else r.cand_count = 9'($urandom_range(24, 1));
         ready = sb.ready_count(len_eff);
         count_eff = (r.cand_count > NUM_SLOTS) ? NUM_SLOTS : int'(r.cand_count);
         if (count_eff > ready) r.cand_count = 9'(ready);
      end else if (pick < 45) begin
         r = random_fields(CMD_LOAD_POS);
         r.cand_index = pick_slot();
         if ($urandom_range(99, 0) < 80) begin
            r.pos_x = near_center(center_x);
            r.pos_y = near_center(center_y);
         end
      end else if (pick < 80) begin
         r = random_fields(CMD_LOAD_ELEM);
         r.cand_index = pick_slot();
         if ($urandom_range(99, 0) < 50) r.elem_index = 7'($urandom_range(15, 0));
         r.elem_value = pick_element();
      end else begin
         r = random_fields(CMD_LOAD_QUERY);
         if ($urandom_range(99, 0) < 50) r.elem_index = 7'($urandom_range(15, 0));
      end
      return r;
   endfunction

   initial begin : stimulus
      logic [7:0] len_cfg;
      logic [33:0] radius_cfg;
      int len_eff;
      int limit;

      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Load every query element and position, and the descriptor entries that the
      // searches below read; later searches stay inside what has been loaded.
      for (int e = 0; e < DESC_SLOTS; e++) load_query(7'(e), 8'($urandom), 8'($urandom));
      for (int s = 0; s < NUM_SLOTS; s++)
         load_position(8'(s), near_center(16'sd0), near_center(16'sd0));
      for (int s = 0; s < NUM_SLOTS; s++) load_element(8'(s), 7'd0, pick_element());
      for (int s = 0; s < FULL_ROWS; s++)
         for (int e = 1; e < DESC_SLOTS; e++) load_element(8'(s), 7'(e), pick_element());
      for (int s = FULL_ROWS; s < SHORT_ROWS; s++)
         for (int e = 1; e < SHORT_ROW_LEN; e++) load_element(8'(s), 7'(e), pick_element());

      // Directed: corner positions and values under the reset settings.
      send_gap_pct = 5;
      rsp_stall_pct = 5;
      load_position(8'd0, -16'sd32768, -16'sd32768);
      load_position(8'd1, 16'sd32767, 16'sd32767);
      load_position(8'd2, 16'sd32767, -16'sd32768);
      load_element(8'd1, 7'd0, 8'd255);
      load_element(8'd255, 7'd127, 8'd0);
      load_query(7'd0, 8'd0, 8'd255);
      load_query(7'd127, 8'd255, 8'd0);
      request_search(16'sd32767, 16'sd32767, 9'd3);
      request_search(16'sd0, 16'sd0, 9'd0);
      wait_idle();

      // Zero length: every candidate inside the widest radius scores zero.
      set_register(CSR_DESC_LENGTH, 34'd0);
      set_register(CSR_RADIUS_SQ, RADIUS_MAX);
      set_register(CSR_SCORE_LIMIT, 34'd65535);
      set_register(CSR_UNUSED, 34'($urandom));
      request_search(-16'sd32768, -16'sd32768, 9'd256);
      request_search(16'sd32767, -16'sd32768, 9'd3);
      request_search(16'sd0, 16'sd0, 9'd511);
      wait_idle();

      // Oversized length, zero radius, zero limit: nothing can win.
      set_register(CSR_DESC_LENGTH, 34'd200);
      set_register(CSR_RADIUS_SQ, 34'd0);
      set_register(CSR_SCORE_LIMIT, 34'd0);
      request_search(16'sd32767, 16'sd32767, 9'd3);
      wait_idle();

      set_register(CSR_SCORE_LIMIT, 34'd65535);
      request_search(16'sd32767, 16'sd32767, 9'd2);
      request_search(-16'sd32768, 16'sd32767, 9'd3);
      wait_idle();

      // Single element over the full candidate list: many equal scores.
      set_register(CSR_DESC_LENGTH, 34'd1);
      set_register(CSR_RADIUS_SQ, 34'd16384);
      request_search(16'sd0, 16'sd0, 9'd256);
      wait_idle();

      // Random phases, each with its own settings; the last one runs without idle gaps or result stalls.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(6, 0))
            0: len_cfg = 8'd1;
            1: len_cfg = 8'($urandom_range(8, 2));
            2: len_cfg = 8'($urandom_range(16, 9));
            3: len_cfg = 8'd0;
            4: len_cfg = 8'd128;
            5: len_cfg = 8'($urandom_range(255, 129));
            default: len_cfg = 8'($urandom_range(32, 1));
         endcase
         case ($urandom_range(5, 0))
            0: radius_cfg = 34'd0;
            1: radius_cfg = 34'd1024;
            2: radius_cfg = 34'd16384;
            3: radius_cfg = 34'd65536;
            4: radius_cfg = RADIUS_MAX;
            default: radius_cfg = {2'($urandom), 32'($urandom)};
         endcase
         len_eff = (len_cfg > DESC_SLOTS) ? DESC_SLOTS : int'(len_cfg);
         case ($urandom_range(3, 0))
            0: limit = 65535;
            1: limit = 0;
            default: limit = len_eff * int'($urandom_range(200, 60));
         endcase
         if (limit > 65535) limit = 65535;
         if ($urandom_range(1, 0) == 0) begin
            center_x = '0;
            center_y = '0;
         end else begin
            center_x = 16'(int'($urandom_range(40000, 0)) - 20000);
            center_y = 16'(int'($urandom_range(40000, 0)) - 20000);
         end
         if (phase == RANDOM_PHASES - 1) begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            send_gap_pct = 3 * int'($urandom_range(2, 0)) * int'($urandom_range(3, 1));
            rsp_stall_pct = 3 * int'($urandom_range(2, 0)) * int'($urandom_range(3, 1));
         end

         set_register(CSR_DESC_LENGTH, 34'(len_cfg));
         set_register(CSR_RADIUS_SQ, radius_cfg);
         set_register(CSR_SCORE_LIMIT, 34'(limit));
         if ($urandom_range(3, 0) == 0) set_register(CSR_UNUSED, 34'($urandom));

         for (int n = 0; n < BEATS_PER_PHASE; n++) send_request(random_item(len_eff));
         wait_idle();
      end

      $display("Run covered %0d accepted request beats and %0d searches, %0d with a match.",
               sb.accepted, sb.searches, sb.hits);
      $display("Field mismatches or stray results seen: %0d.", sb.errors);
      if (sb.errors == 0) begin
         $display("gated_descriptor_best_match_top test passed");
      end else begin
         $display("gated_descriptor_best_match_top test failed");
      end
      $finish;
   end

endmodule
